// ===== hw/rtl/rc4sc_pkg.sv =====
package rc4sc_pkg;

  localparam int PERM_SIZE = 256;
  localparam int PERM_AW = 8;
  localparam int KEY_W = 128;
  localparam int KEY_IDX_W = 4;
  localparam int CFG_IDX_W = 2;
  localparam logic [PERM_AW-1:0] PERM_LAST = PERM_AW'(PERM_SIZE - 1);

  typedef enum logic [1:0] {
    FUNC_REKEY = 2'd0,
    FUNC_CRYPT = 2'd1,
    FUNC_SKIP  = 2'd2
  } func_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_KEY_LOW  = 2'd0,
    REG_KEY_HIGH = 2'd1
  } reg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INIT,
    ST_KRD_I,
    ST_KRD_J,
    ST_KWR_I,
    ST_KWR_J,
    ST_RD_J,
    ST_WR_I,
    ST_WR_J,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic               rd_en;
    logic [PERM_AW-1:0] rd_addr;
    logic               wr_en;
    logic [PERM_AW-1:0] wr_addr;
    logic [7:0]         wr_data;
  } mem_req_t;

  function automatic logic [7:0] key_byte(input logic [KEY_W-1:0] key,
                                          input logic [KEY_IDX_W-1:0] kpos);
    key_byte = key[{kpos, 3'b000} +: 8];
  endfunction

endpackage

// ===== hw/rtl/rc4sc_perm_ram.sv =====
module rc4sc_perm_ram (
  input  logic                clk,
  input  rc4sc_pkg::mem_req_t req,
  output logic [7:0]          rdata
);
  import rc4sc_pkg::*;

  logic [7:0] mem [PERM_SIZE];

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rdata <= mem[req.rd_addr];
    end
  end

endmodule

// ===== hw/rtl/rc4sc_ctrl.sv =====
module rc4sc_ctrl #(
  parameter int KEY_BYTES = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [rc4sc_pkg::KEY_W-1:0]   key,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [1:0]                    func,
  input  logic [7:0]                    data_in,
  input  logic                          last_in,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [7:0]                    data_out,
  output logic                          keyed,
  output logic [31:0]                   position,
  output logic                          last_out,
  output rc4sc_pkg::mem_req_t           req,
  input  logic [7:0]                    rdata
);
  import rc4sc_pkg::*;

  state_t                 state, state_next;
  logic [PERM_AW-1:0]     cnt;
  logic [KEY_IDX_W-1:0]   kpos;
  logic [7:0]             idx_i, idx_j, si, sj;
  logic [31:0]            step_count, pos;
  logic                   keyed_flag, is_crypt, fwd, last;
  logic [7:0]             data;

  logic                   accept, advance, out_free;
  logic [7:0]             sched_j, strm_j, ks_addr, ks;

  assign accept   = in_valid && !in_stall;
  assign advance  = accept && keyed_flag && (func == FUNC_CRYPT || func == FUNC_SKIP);
  assign out_free = !out_valid || !out_stall;
  assign sched_j  = idx_j + rdata + key_byte(key, kpos);
  assign strm_j   = idx_j + rdata;
  assign ks_addr  = si + sj;
  assign ks       = keyed_flag ? (fwd ? si : rdata) : 8'h00;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          priority if (func == FUNC_REKEY) begin
            state_next = ST_INIT;
          end else if (func == FUNC_CRYPT) begin
            state_next = keyed_flag ? ST_RD_J : ST_OUT;
          end else if (func == FUNC_SKIP && keyed_flag) begin
            state_next = ST_RD_J;
          end else begin
            state_next = ST_IDLE;
          end
        end
      end
      ST_INIT:  state_next = (cnt == PERM_LAST) ? ST_KRD_I : ST_INIT;
      ST_KRD_I: state_next = ST_KRD_J;
      ST_KRD_J: state_next = ST_KWR_I;
      ST_KWR_I: state_next = ST_KWR_J;
      ST_KWR_J: state_next = (cnt == PERM_LAST) ? ST_IDLE : ST_KRD_I;
      ST_RD_J:  state_next = ST_WR_I;
      ST_WR_I:  state_next = ST_WR_J;
      ST_WR_J:  state_next = is_crypt ? ST_OUT : ST_IDLE;
      ST_OUT:   state_next = out_free ? ST_IDLE : ST_OUT;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall    = (state != ST_IDLE);
    req         = '0;
    unique case (state)
      ST_IDLE: begin
        req.rd_en   = advance;
        req.rd_addr = idx_i + 8'd1;
      end
      ST_INIT: begin
        req.wr_en   = 1'b1;
        req.wr_addr = cnt;
        req.wr_data = cnt;
      end
      ST_KRD_I: begin
        req.rd_en   = 1'b1;
        req.rd_addr = cnt;
      end
      ST_KRD_J: begin
        req.rd_en   = 1'b1;
        req.rd_addr = sched_j;
      end
      ST_KWR_I: begin
        req.wr_en   = 1'b1;
        req.wr_addr = cnt;
        req.wr_data = rdata;
      end
      ST_KWR_J: begin
        req.wr_en   = 1'b1;
        req.wr_addr = idx_j;
        req.wr_data = si;
      end
      ST_RD_J: begin
        req.rd_en   = 1'b1;
        req.rd_addr = strm_j;
      end
      ST_WR_I: begin
        req.wr_en   = 1'b1;
        req.wr_addr = idx_i;
        req.wr_data = rdata;
      end
      ST_WR_J: begin
        req.wr_en   = 1'b1;
        req.wr_addr = idx_j;
        req.wr_data = si;
        req.rd_en   = 1'b1;
        req.rd_addr = ks_addr;
      end
      ST_OUT: begin
        req = '0;
      end
      default: begin
        req = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      idx_i      <= '0;
      idx_j      <= '0;
      step_count <= '0;
      keyed_flag <= 1'b0;
      out_valid  <= 1'b0;
      cnt        <= '0;
      kpos       <= '0;
    end else begin
      state <= state_next;
      if (accept && func == FUNC_REKEY) begin
        cnt <= '0;
      end
      if (advance) begin
        idx_i      <= idx_i + 8'd1;
        step_count <= step_count + 32'd1;
      end
      unique case (state)
        ST_INIT: begin
          cnt <= cnt + 8'd1;
          if (cnt == PERM_LAST) begin
            idx_j <= '0;
            kpos  <= '0;
          end
        end
        ST_KRD_J: begin
          si    <= rdata;
          idx_j <= sched_j;
        end
        ST_KWR_J: begin
          cnt  <= cnt + 8'd1;
          kpos <= (kpos == KEY_IDX_W'(KEY_BYTES - 1)) ? '0 : kpos + 1'b1;
          if (cnt == PERM_LAST) begin
            idx_i      <= '0;
            idx_j      <= '0;
            step_count <= '0;
            keyed_flag <= 1'b1;
          end
        end
        ST_RD_J: begin
          si    <= rdata;
          idx_j <= strm_j;
        end
        ST_WR_I: begin
          sj <= rdata;
        end
        ST_WR_J: begin
          fwd <= (ks_addr == idx_j);
        end
        default: begin
        end
      endcase
      if (state == ST_OUT && out_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      is_crypt <= (func == FUNC_CRYPT);
      data     <= data_in;
      last     <= last_in;
      pos      <= step_count;
    end
    if (state == ST_OUT && out_free) begin
      data_out <= data ^ ks;
      keyed    <= keyed_flag;
      position <= pos;
      last_out <= last;
    end
  end

endmodule

// ===== hw/rtl/rc4_stream_cipher_core.sv =====
// Channel  Direction  Handshake           Payload
// cfg      in         cfg_valid/ready     cfg_index, cfg_data
// in       in         in_valid/in_stall   func, data_in, last_in
// out      out        out_valid/out_stall data_out, keyed, position, last_out
//
// A keyed crypt transaction steps through RD_J, WR_I and WR_J to OUT, where the
// result register loads, and frees the input when OUT is left; a keyed skip
// steps through RD_J, WR_I and WR_J back to IDLE, and an unkeyed crypt goes
// straight to OUT, where its result loads. The keyed paths are set by the
// dependent reads and the swap through the single permutation memory.
// A rekey fills all 256 entries, then runs one swap step per entry.
// Reset is synchronous and clears the indices, the count and the keyed flag.
// The input stalls while a transaction is at work; a stalled result holds in
// the output register while the next input transaction is accepted, and the
// next result then waits, with the input stalled, until the register is free.
module rc4_stream_cipher_core #(
  parameter int KEY_BYTES = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [rc4sc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [63:0]                     cfg_data,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [1:0]                      func,
  input  logic [7:0]                      data_in,
  input  logic                            last_in,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [7:0]                      data_out,
  output logic                            keyed,
  output logic [31:0]                     position,
  output logic                            last_out
);
  import rc4sc_pkg::*;

  logic [63:0] key_low, key_high;
  mem_req_t    req;
  logic [7:0]  rdata;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_low  <= '0;
      key_high <= '0;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == REG_KEY_LOW) begin
        key_low <= cfg_data;
      end
      if (cfg_index == REG_KEY_HIGH) begin
        key_high <= cfg_data;
      end
    end
  end

  rc4sc_ctrl #(
    .KEY_BYTES(KEY_BYTES)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .key       ({key_high, key_low}),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .func      (func),
    .data_in   (data_in),
    .last_in   (last_in),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .data_out  (data_out),
    .keyed     (keyed),
    .position  (position),
    .last_out  (last_out),
    .req       (req),
    .rdata     (rdata)
  );

  rc4sc_perm_ram u_ram (
    .clk   (clk),
    .req   (req),
    .rdata (rdata)
  );

endmodule

// ===== hw/rtl/rc4sc_checker.sv =====
module rc4sc_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic [1:0]  func,
  input logic        out_valid,
  input logic        out_stall,
  input logic [7:0]  data_out,
  input logic        keyed,
  input logic [31:0] position,
  input logic        last_out
);
  import rc4sc_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(data_out) && $stable(keyed)
      && $stable(position) && $stable(last_out))
    else $error("Stalled result changed.");

  a_unkeyed_pos: assert property (@(posedge clk) disable iff (rst)
    out_valid && !keyed |-> position == 32'd0)
    else $error("Unkeyed result with nonzero position.");

  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && (func == FUNC_REKEY || func == FUNC_CRYPT) |=> in_stall)
    else $error("Input not stalled after a rekey or crypt transaction.");

  a_rekey_long: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && func == FUNC_REKEY |=> ##8 in_stall)
    else $error("Key schedule finished too early.");

endmodule

bind rc4_stream_cipher_core rc4sc_checker u_rc4sc_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .func      (func),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .data_out  (data_out),
  .keyed     (keyed),
  .position  (position),
  .last_out  (last_out)
);
